### hdl/muscl_minmod_face_reconstruct_macros.svh
// Assertion macros for the MUSCL face reconstruction block.
// Included by the top level; no other dependencies.
`ifndef MUSCL_MINMOD_FACE_RECONSTRUCT_MACROS_SVH
`define MUSCL_MINMOD_FACE_RECONSTRUCT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MMR_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MMR_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMR_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define MMR_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

### hdl/mmr_pkg.sv
// Package for the MUSCL face reconstruction block: widths, stage types, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mmr_pkg;
    localparam int DataWidth = 32;
    localparam int QuoWidth  = 2 * DataWidth + 1;
    localparam int DivStages = QuoWidth;

    typedef logic signed [DataWidth-1:0] t_word;
    typedef logic [DataWidth-1:0]        t_mag;
    typedef logic [2*DataWidth-1:0]      t_prod;

    typedef struct packed {
        t_word depth_above, depth_mid, depth_below;
        t_word xvel_above, xvel_mid, xvel_below;
        t_word yvel_above, yvel_mid, yvel_below;
        t_word bed_above, bed_mid, bed_below;
    } t_in;

    typedef struct packed {
        t_word depth_face_lo, depth_face_hi;
        t_word xvel_face_lo, xvel_face_hi;
        t_word yvel_face_lo, yvel_face_hi;
        t_word bed_face_lo, bed_face_hi;
        logic  divide_fault;
    } t_out;

    localparam t_word WMax = {1'b0, {(DataWidth-1){1'b1}}};
    localparam t_word WMin = {1'b1, {(DataWidth-1){1'b0}}};

    typedef struct packed {
        t_word r;
        logic  f;
    } t_sat;

    function automatic t_sat sat_add(t_word a, t_word b);
        logic signed [DataWidth:0] s;
        t_sat o;
        s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
        o.f = (s[DataWidth] != s[DataWidth-1]);
        o.r = o.f ? (s[DataWidth] ? WMin : WMax) : s[DataWidth-1:0];
        return o;
    endfunction

    function automatic t_sat sat_sub(t_word a, t_word b);
        logic signed [DataWidth:0] s;
        t_sat o;
        s = {a[DataWidth-1], a} - {b[DataWidth-1], b};
        o.f = (s[DataWidth] != s[DataWidth-1]);
        o.r = o.f ? (s[DataWidth] ? WMin : WMax) : s[DataWidth-1:0];
        return o;
    endfunction

    function automatic t_word minmod(t_word a, t_word b);
        t_word o;
        if (!a[DataWidth-1] && !b[DataWidth-1]) begin
            o = (a < b) ? a : b;
        end else if ((a[DataWidth-1] || a == '0) && (b[DataWidth-1] || b == '0)) begin
            o = (a > b) ? a : b;
        end else begin
            o = '0;
        end
        return o;
    endfunction

    // signed divide by two, rounding toward zero
    function automatic t_word half(t_word a);
        t_word t;
        t = a + t_word'(a[DataWidth-1]);
        return t >>> 1;
    endfunction

    function automatic t_mag mag(t_word a);
        return a[DataWidth-1] ? t_mag'(-a) : t_mag'(a);
    endfunction
endpackage
`default_nettype wire

### hdl/mmr_if.sv
// Valid/ready channel carrying one payload of type T.
// No dependencies; the payload type T is a parameter.
`timescale 1ns / 1ps
`default_nettype none
interface mmr_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/mmr_slope.sv
// Front stages: differences, minmod limiting, depth and bed faces, products.
// Depends on mmr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmr_slope (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire mmr_pkg::t_in  i_data,
    output logic               o_valid,
    output mmr_pkg::t_word     o_hlo,
    output mmr_pkg::t_word     o_hhi,
    output mmr_pkg::t_word     o_zlo,
    output mmr_pkg::t_word     o_zhi,
    output mmr_pkg::t_word     o_hm,
    output mmr_pkg::t_word     o_um,
    output mmr_pkg::t_word     o_vm,
    output mmr_pkg::t_prod     o_p [4],
    output logic [3:0]         o_pneg,
    output logic               o_fault
);
    import mmr_pkg::*;

    // stage 1: differences
    logic  r_v1;
    t_word r_dh1, r_dh2, r_du1, r_du2, r_dv1, r_dv2, r_dz1, r_dz2, r_hm1, r_um1, r_vm1, r_zm1;
    logic  r_f1;
    // stage 2: limited slopes
    logic  r_v2;
    t_word r_mh, r_su, r_sv, r_mzh, r_hm2, r_um2, r_vm2, r_zm2;
    logic  r_f2;
    // stage 3: faces
    logic  r_v3;
    t_word r_hlo3, r_hhi3, r_zlo3, r_zhi3, r_su3, r_sv3, r_hm3, r_um3, r_vm3;
    logic  r_f3;
    // stage 4: products
    logic  r_v4;
    logic  r_f4;
    t_word r_hlo4, r_hhi4, r_zlo4, r_zhi4, r_hm4, r_um4, r_vm4;
    t_prod r_p4 [4];
    logic [3:0] r_pn4;

    t_sat n_s [8];
    t_sat n_dzh1, n_dzh2, n_t, n_hlo, n_hhi, n_zlo, n_zhi;
    t_word n_hs, n_tt;
    t_word n_sl [4];
    t_word n_fc [4];

    always_comb begin
        n_s[0] = sat_sub(i_data.depth_mid, i_data.depth_below);
        n_s[1] = sat_sub(i_data.depth_above, i_data.depth_mid);
        n_s[2] = sat_sub(i_data.xvel_mid, i_data.xvel_below);
        n_s[3] = sat_sub(i_data.xvel_above, i_data.xvel_mid);
        n_s[4] = sat_sub(i_data.yvel_mid, i_data.yvel_below);
        n_s[5] = sat_sub(i_data.yvel_above, i_data.yvel_mid);
        n_s[6] = sat_sub(i_data.bed_mid, i_data.bed_below);
        n_s[7] = sat_sub(i_data.bed_above, i_data.bed_mid);
        n_dzh1 = sat_add(r_dz1, r_dh1);
        n_dzh2 = sat_add(r_dz2, r_dh2);
        n_hs   = half(r_mh);
        n_t    = sat_sub(r_mzh, r_mh);
        n_tt   = half(n_t.r);
        n_hlo  = sat_sub(r_hm2, n_hs);
        n_hhi  = sat_add(r_hm2, n_hs);
        n_zlo  = sat_sub(r_zm2, n_tt);
        n_zhi  = sat_add(r_zm2, n_tt);
        // slope/face pairs: u lo, u hi, v lo, v hi
        n_sl[0] = r_su3; n_fc[0] = r_hhi3;
        n_sl[1] = r_su3; n_fc[1] = r_hlo3;
        n_sl[2] = r_sv3; n_fc[2] = r_hhi3;
        n_sl[3] = r_sv3; n_fc[3] = r_hlo3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (i_en) begin
            r_dh1 <= n_s[0].r; r_dh2 <= n_s[1].r;
            r_du1 <= n_s[2].r; r_du2 <= n_s[3].r;
            r_dv1 <= n_s[4].r; r_dv2 <= n_s[5].r;
            r_dz1 <= n_s[6].r; r_dz2 <= n_s[7].r;
            r_f1  <= n_s[0].f | n_s[1].f | n_s[2].f | n_s[3].f
                   | n_s[4].f | n_s[5].f | n_s[6].f | n_s[7].f
                   | (i_data.depth_mid == '0);
            r_hm1 <= i_data.depth_mid; r_um1 <= i_data.xvel_mid;
            r_vm1 <= i_data.yvel_mid;  r_zm1 <= i_data.bed_mid;

            r_mh  <= minmod(r_dh1, r_dh2);
            r_su  <= minmod(r_du1, r_du2);
            r_sv  <= minmod(r_dv1, r_dv2);
            r_mzh <= minmod(n_dzh1.r, n_dzh2.r);
            r_f2  <= r_f1 | n_dzh1.f | n_dzh2.f;
            r_hm2 <= r_hm1; r_um2 <= r_um1; r_vm2 <= r_vm1; r_zm2 <= r_zm1;

            r_hlo3 <= n_hlo.r; r_hhi3 <= n_hhi.r;
            r_zlo3 <= n_zlo.r; r_zhi3 <= n_zhi.r;
            r_f3   <= r_f2 | n_t.f | n_hlo.f | n_hhi.f | n_zlo.f | n_zhi.f;
            r_su3 <= r_su; r_sv3 <= r_sv;
            r_hm3 <= r_hm2; r_um3 <= r_um2; r_vm3 <= r_vm2;

            for (int k = 0; k < 4; k++) begin
                r_p4[k]  <= mag(n_sl[k]) * mag(n_fc[k]);
                r_pn4[k] <= (n_sl[k][DataWidth-1] != n_fc[k][DataWidth-1])
                          != r_hm3[DataWidth-1];
            end
            r_hlo4 <= r_hlo3; r_hhi4 <= r_hhi3; r_zlo4 <= r_zlo3; r_zhi4 <= r_zhi3;
            r_hm4 <= r_hm3; r_um4 <= r_um3; r_vm4 <= r_vm3;
            r_f4  <= r_f3;
        end
    end

    assign o_valid = r_v4;
    assign o_hlo = r_hlo4;
    assign o_hhi = r_hhi4;
    assign o_zlo = r_zlo4;
    assign o_zhi = r_zhi4;
    assign o_hm  = r_hm4;
    assign o_um  = r_um4;
    assign o_vm  = r_vm4;
    assign o_p   = r_p4;
    assign o_pneg = r_pn4;
    assign o_fault = r_f4;
endmodule
`default_nettype wire

### hdl/mmr_div.sv
// Pipelined restoring divider: four products over 2*|h|, one quotient bit a stage.
// Depends on mmr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmr_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire mmr_pkg::t_prod i_p [4],
    input  wire mmr_pkg::t_mag  i_d,
    output logic               o_valid,
    output logic [mmr_pkg::QuoWidth-1:0] o_q [4]
);
    import mmr_pkg::*;

    localparam int RemW = DataWidth + 2;
    typedef logic [RemW-1:0]     t_rem;
    typedef logic [QuoWidth-1:0] t_quo;

    // divisor is |h| with one zero below, i.e. 2*|h|; with a zero divisor a
    // quotient bit is set only for a nonzero partial remainder, so q is
    // nonzero exactly when the product is
    logic  r_v [DivStages];
    t_rem  r_r [DivStages][4];
    t_quo  r_n [DivStages][4];
    t_mag  r_d [DivStages];

    t_rem n_r [DivStages][4];
    t_quo n_n [DivStages][4];

    always_comb begin
        for (int s = 0; s < DivStages; s++) begin
            for (int k = 0; k < 4; k++) begin
                t_rem a;
                t_rem dd;
                t_quo src;
                t_rem rin;
                if (s == 0) begin
                    src = {1'b0, i_p[k]};
                    rin = '0;
                    dd  = t_rem'({i_d, 1'b0});
                end else begin
                    src = r_n[s-1][k];
                    rin = r_r[s-1][k];
                    dd  = t_rem'({r_d[s-1], 1'b0});
                end
                a = {rin[RemW-2:0], src[QuoWidth-1]};
                if (a >= dd && a != '0) begin
                    n_r[s][k] = a - dd;
                    n_n[s][k] = {src[QuoWidth-2:0], 1'b1};
                end else begin
                    n_r[s][k] = a;
                    n_n[s][k] = {src[QuoWidth-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DivStages; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < DivStages; s++) r_v[s] <= r_v[s-1];
        end
        if (i_en) begin
            r_d[0] <= i_d;
            for (int s = 1; s < DivStages; s++) r_d[s] <= r_d[s-1];
            for (int s = 0; s < DivStages; s++) begin
                for (int k = 0; k < 4; k++) begin
                    r_r[s][k] <= n_r[s][k];
                    r_n[s][k] <= n_n[s][k];
                end
            end
        end
    end

    assign o_valid = r_v[DivStages-1];
    always_comb begin
        for (int k = 0; k < 4; k++) o_q[k] = r_n[DivStages-1][k];
    end
endmodule
`default_nettype wire

### hdl/muscl_minmod_face_reconstruct.sv
// MUSCL minmod face reconstruction, top level.
// Channels: in carries the 3-row stencil of h, u, v, z; out carries the faces.
// Pipeline: 4 slope stages + 65 divider stages + output register (the final
// clamp is combinational in front of it), 70 register stages.
// Throughput: one transaction per cycle while the receiver does not stall.
// The divider's one-bit-a-stage pipeline sets the latency.
// Reset (synchronous, active low) clears all valid bits; no result is
// presented until a new transaction enters.
// When the receiver stalls, the whole pipeline holds and in.ready drops
// only if the output register is occupied and not taken; nothing is lost
// or repeated.
// A zero center depth saturates any nonzero scaled slope and raises
// divide_fault, as does any clamp along the way.
// Depends on mmr_pkg, mmr_if, mmr_slope, mmr_div and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "muscl_minmod_face_reconstruct_macros.svh"
module muscl_minmod_face_reconstruct (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mmr_if.sink       in_ch,
    mmr_if.source     out_ch
);
    import mmr_pkg::*;

    localparam int Lat = DivStages;

    logic en;
    logic s_valid;
    t_word hlo, hhi, zlo, zhi, hm, um, vm;
    t_prod p [4];
    logic [3:0] pneg;
    logic sfault;
    logic d_valid;
    logic [QuoWidth-1:0] q [4];

    // side data delayed alongside divider
    t_word r_dl [Lat][6];
    logic  r_dn [Lat][4];
    logic  r_df [Lat];
    logic  r_dz [Lat];

    logic r_ov;
    t_out r_od;
    t_out n_od;

    assign en = !r_ov || out_ch.ready;
    assign in_ch.ready = en;

    mmr_slope u_slope (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(in_ch.valid && en), .i_data(in_ch.data),
        .o_valid(s_valid), .o_hlo(hlo), .o_hhi(hhi), .o_zlo(zlo), .o_zhi(zhi),
        .o_hm(hm), .o_um(um), .o_vm(vm), .o_p(p), .o_pneg(pneg), .o_fault(sfault)
    );

    mmr_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(s_valid),
        .i_p(p), .i_d(mag(hm)), .o_valid(d_valid), .o_q(q)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl[0][0] <= hlo; r_dl[0][1] <= hhi; r_dl[0][2] <= zlo;
            r_dl[0][3] <= zhi; r_dl[0][4] <= um;  r_dl[0][5] <= vm;
            for (int k = 0; k < 4; k++) r_dn[0][k] <= pneg[k];
            r_df[0] <= sfault;
            r_dz[0] <= (hm == '0);
            for (int s = 1; s < Lat; s++) begin
                r_dl[s] <= r_dl[s-1];
                r_dn[s] <= r_dn[s-1];
                r_df[s] <= r_df[s-1];
                r_dz[s] <= r_dz[s-1];
            end
        end
    end

    // final: clamp quotient and add it to or subtract it from center velocity
    always_comb begin
        t_sat  fs [4];
        t_word base [4];
        logic  sub [4];
        logic  f;
        t_mag  qm;
        logic  big;
        logic signed [DataWidth+1:0] acc;
        f = r_df[Lat-1];
        base[0] = r_dl[Lat-1][4]; base[1] = r_dl[Lat-1][4];
        base[2] = r_dl[Lat-1][5]; base[3] = r_dl[Lat-1][5];
        for (int k = 0; k < 4; k++) begin
            // lo faces subtract the scaled slope, hi faces add it
            sub[k] = (k % 2 == 0) ? !r_dn[Lat-1][k] : r_dn[Lat-1][k];
            big = r_dz[Lat-1] ? (q[k] != '0) : (q[k][QuoWidth-1:DataWidth] != '0);
            // a zero product with zero depth gives q zero: face equals center
            qm  = big ? {DataWidth{1'b1}} : q[k][DataWidth-1:0];
            if (r_dz[Lat-1] && q[k] != '0) qm = {DataWidth{1'b1}};
            acc = sub[k] ? ($signed({{2{base[k][DataWidth-1]}}, base[k]})
                            - $signed({2'b00, qm}))
                         : ($signed({{2{base[k][DataWidth-1]}}, base[k]})
                            + $signed({2'b00, qm}));
            fs[k].f = big || (acc > $signed({2'b00, WMax}))
                    || (acc < $signed({{2{1'b1}}, WMin}));
            fs[k].r = (acc > $signed({2'b00, WMax})) ? WMax
                    : (acc < $signed({{2{1'b1}}, WMin})) ? WMin
                    : acc[DataWidth-1:0];
            f = f | fs[k].f;
        end
        n_od.depth_face_lo = r_dl[Lat-1][0];
        n_od.depth_face_hi = r_dl[Lat-1][1];
        n_od.bed_face_lo   = r_dl[Lat-1][2];
        n_od.bed_face_hi   = r_dl[Lat-1][3];
        n_od.xvel_face_lo  = fs[0].r;
        n_od.xvel_face_hi  = fs[1].r;
        n_od.yvel_face_lo  = fs[2].r;
        n_od.yvel_face_hi  = fs[3].r;
        n_od.divide_fault  = f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= d_valid;
        end
        if (en) begin
            r_od <= n_od;
        end
    end

    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_od;

    `MMR_ASSERT_RST(a_rst_clear, i_clk, !$past(i_rst_n) |-> !r_ov, "valid after reset")
    `MMR_ASSERT_IMPL(a_hold, i_clk, i_rst_n, (r_ov && !out_ch.ready) |=> (r_ov && $stable(r_od)), "stalled result changed")
    `MMR_ASSERT_IMPL(a_ready, i_clk, i_rst_n, in_ch.ready == (!r_ov || out_ch.ready), "ready mismatch")
endmodule
`default_nettype wire
